FILE: hdl/sagc_pkg.sv
// ----------------------------------------------------------------------------
// sagc_pkg
// Shared types, register codes and reset values of the spectrum gain control.
// ----------------------------------------------------------------------------
`default_nettype none

package sagc_pkg;

    localparam int SAGC_BINS        = 64;
    localparam int SAGC_QUEUE_DEPTH = 4;

    localparam logic [8:0]  SAGC_SMOOTHING_RESET = 9'd77;
    localparam logic [7:0]  SAGC_MIN_AMP_RESET   = 8'd20;
    localparam logic [7:0]  SAGC_TARGET_RESET    = 8'd200;
    localparam logic [7:0]  SAGC_SPEED_RESET     = 8'd1;
    localparam logic [15:0] SAGC_MIN_GAIN_RESET  = 16'd256;
    localparam logic [15:0] SAGC_MAX_GAIN_RESET  = 16'd25600;
    localparam logic [15:0] SAGC_THRESHOLD_RESET = 16'd13;
    localparam logic [15:0] SAGC_UNITY_GAIN      = 16'd256;
    localparam logic [8:0]  SAGC_FULL_WEIGHT     = 9'd256;

    typedef enum logic [2:0] {
        CFG_SMOOTHING_FACTOR  = 3'd0,
        CFG_MINIMUM_AMPLITUDE = 3'd1,
        CFG_PEAK_GOAL         = 3'd2,
        CFG_STEP_RATE         = 3'd3,
        CFG_MIN_GAIN          = 3'd4,
        CFG_MAX_GAIN          = 3'd5,
        CFG_CHANGE_THRESHOLD  = 3'd6
    } sagc_cfg_idx_t;

    typedef struct packed {
        logic [8:0]  smoothing_factor;
        logic [7:0]  minimum_amplitude;
        logic [7:0]  peak_goal;
        logic [7:0]  step_rate;
        logic [15:0] min_gain;
        logic [15:0] max_gain;
        logic [15:0] change_threshold;
    } sagc_cfg_t;

    typedef struct packed {
        logic [7:0] bar_level;
        logic       last_of_frame;
    } sagc_in_t;

    typedef struct packed {
        logic [15:0] gain_value;
        logic        gain_changed;
    } sagc_out_t;

    typedef struct packed {
        logic [7:0] bar_level;
        logic       last_of_frame;
        logic       in_range;
    } sagc_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sagc_qstat_t;

endpackage

`default_nettype wire

FILE: hdl/sagc_ram.sv
// ----------------------------------------------------------------------------
// sagc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sagc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/sagc_queue.sv
// ----------------------------------------------------------------------------
// sagc_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module sagc_queue
    import sagc_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = SAGC_QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output sagc_qstat_t           stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = data_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

FILE: hdl/sagc_front.sv
// ----------------------------------------------------------------------------
// sagc_front
// Accepts bins, tracks the bin position and tags each bin for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module sagc_front
    import sagc_pkg::*;
#(
    parameter int BINS = SAGC_BINS
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       bin_valid,
    output logic                                            bin_ready,
    input  wire sagc_in_t                                   bin_data,
    input  wire logic                                       clearing,
    input  wire sagc_qstat_t                                q_stat,
    output logic                                            push,
    output sagc_item_t                                      item,
    output logic [((BINS > 1) ? $clog2(BINS) : 1)-1:0]      addr
);

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int PW = $clog2(BINS + 1);

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          in_range;

    assign in_range  = (pos_reg < PW'(BINS));
    assign bin_ready = !q_stat.full && !clearing;
    assign push      = bin_valid && bin_ready;

    assign item.bar_level     = bin_data.bar_level;
    assign item.last_of_frame = bin_data.last_of_frame;
    assign item.in_range      = in_range;
    assign addr               = pos_reg[AW-1:0];

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (bin_data.last_of_frame)
            begin
                pos_next = '0;
            end
            else if (in_range)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sagc_back.sv
// ----------------------------------------------------------------------------
// sagc_back
// Bin smoothing, frame peak tracking, gain update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sagc_back
    import sagc_pkg::*;
#(
    parameter int BINS = SAGC_BINS
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire sagc_cfg_t                                  cfg,
    input  wire sagc_item_t                                 head_item,
    input  wire logic [((BINS > 1) ? $clog2(BINS) : 1)-1:0] head_addr,
    input  wire sagc_qstat_t                                q_stat,
    output logic                                            pop,
    output logic                                            clearing,
    output logic                                            gain_valid,
    input  wire logic                                       gain_ready,
    output sagc_out_t                                       gain_data
);

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;

    logic                advance;
    logic                clear_active_reg;
    logic                clear_active_next;
    logic [AW-1:0]       clr_addr_reg;
    logic [AW-1:0]       clr_addr_next;

    // smoothing stage
    logic                s2_valid_reg;
    sagc_item_t          s2_item_reg;
    logic [AW-1:0]       s2_addr_reg;
    logic                fwd_hit_reg;
    logic [7:0]          fwd_data_reg;
    logic [7:0]          rdata;
    logic [7:0]          old_level;
    logic [8:0]          f_sat;
    logic [16:0]         prod_new;
    logic [16:0]         prod_old;
    logic [16:0]         filt_sum;
    logic [7:0]          smoothed;
    logic                s2_write;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [7:0]          ram_wdata;

    // peak stage
    logic                s3_valid_reg;
    logic                s3_last_reg;
    logic                s3_in_range_reg;
    logic [7:0]          s3_level_reg;
    logic [7:0]          peak_reg;
    logic [7:0]          peak_eff;
    logic [8:0]          error_diff;

    // step stage
    logic                s4_valid_reg;
    logic                s4_below_reg;
    logic signed [8:0]   s4_diff_reg;
    logic signed [17:0]  step_prod;

    // gain stage
    logic                s5_valid_reg;
    logic                s5_below_reg;
    logic signed [17:0]  s5_step_reg;
    logic signed [18:0]  gain_sum;
    logic signed [18:0]  min_s;
    logic signed [18:0]  max_s;
    logic                in_bounds;
    logic [16:0]         step_mag;
    logic                flag_set;
    logic [15:0]         gain_upd;
    logic [15:0]         gain_clamped;
    logic                frame_fire;
    logic [15:0]         gain_reg;
    logic [15:0]         gain_next;
    logic                flag_reg;
    logic                flag_next;
    logic                flag_report;
    logic                out_valid_reg;
    sagc_out_t           out_data_reg;

    assign advance  = !out_valid_reg || gain_ready;
    assign pop      = advance && !q_stat.empty && !clear_active_reg;
    assign clearing = clear_active_reg;

    // clearing pass over the bin memory after reset
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clr_addr_next     = clr_addr_reg;
        if (clear_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(BINS - 1))
            begin
                clear_active_next = 1'b0;
            end
        end
    end

    assign f_sat     = (cfg.smoothing_factor > SAGC_FULL_WEIGHT) ? SAGC_FULL_WEIGHT
                                                                 : cfg.smoothing_factor;
    assign old_level = fwd_hit_reg ? fwd_data_reg : rdata;
    assign prod_new  = {8'd0, f_sat} * {9'd0, s2_item_reg.bar_level};
    assign prod_old  = {8'd0, SAGC_FULL_WEIGHT - f_sat} * {9'd0, old_level};
    assign filt_sum  = prod_new + prod_old;
    assign smoothed  = filt_sum[15:8];
    assign s2_write  = s2_valid_reg && s2_item_reg.in_range && advance;

    assign ram_we    = clear_active_reg || s2_write;
    assign ram_waddr = clear_active_reg ? clr_addr_reg : s2_addr_reg;
    assign ram_wdata = clear_active_reg ? 8'd0 : smoothed;

    sagc_ram #(
        .WIDTH (8),
        .DEPTH (BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (head_addr),
        .rdata (rdata)
    );

    assign peak_eff   = (s3_in_range_reg && (s3_level_reg > peak_reg)) ? s3_level_reg : peak_reg;
    assign error_diff = {1'b0, cfg.peak_goal} - {1'b0, peak_eff};

    assign step_prod = 18'($signed({1'b0, cfg.step_rate})) * 18'(s4_diff_reg);

    assign gain_sum  = $signed({3'b000, gain_reg}) + 19'(s5_step_reg);
    assign min_s     = $signed({3'b000, cfg.min_gain});
    assign max_s     = $signed({3'b000, cfg.max_gain});
    assign in_bounds = (gain_sum > min_s) && (gain_sum < max_s);
    assign step_mag  = (s5_step_reg < 0) ? 17'(-s5_step_reg) : 17'(s5_step_reg);
    assign flag_set  = in_bounds && (step_mag > {1'b0, cfg.change_threshold});
    assign gain_upd  = in_bounds ? gain_sum[15:0] : gain_reg;
    assign gain_clamped = (gain_upd < cfg.min_gain) ? cfg.min_gain : gain_upd;
    assign frame_fire   = s5_valid_reg && advance;
    assign flag_report  = s5_below_reg ? flag_reg : (flag_reg | flag_set);

    always_comb
    begin
        gain_next = gain_reg;
        flag_next = flag_reg;
        if (frame_fire)
        begin
            flag_next = 1'b0;
            if (!s5_below_reg)
            begin
                gain_next = gain_clamped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clr_addr_reg     <= '0;
            s2_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            s3_valid_reg     <= 1'b0;
            peak_reg         <= '0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            gain_reg         <= SAGC_UNITY_GAIN;
            flag_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clr_addr_reg     <= clr_addr_next;
            gain_reg         <= gain_next;
            flag_reg         <= flag_next;
            if (advance)
            begin
                s2_valid_reg <= pop;
                fwd_hit_reg  <= pop && s2_write && (s2_addr_reg == head_addr);
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg && s3_last_reg;
                s5_valid_reg <= s4_valid_reg;
                if (s3_valid_reg)
                begin
                    peak_reg <= s3_last_reg ? 8'd0 : peak_eff;
                end
            end
            if (frame_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (gain_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_item_reg     <= head_item;
            s2_addr_reg     <= head_addr;
            fwd_data_reg    <= smoothed;
            s3_last_reg     <= s2_item_reg.last_of_frame;
            s3_in_range_reg <= s2_item_reg.in_range;
            s3_level_reg    <= smoothed;
            s4_below_reg    <= (peak_eff < cfg.minimum_amplitude);
            s4_diff_reg     <= $signed(error_diff);
            s5_below_reg    <= s4_below_reg;
            s5_step_reg     <= step_prod;
        end
        if (frame_fire)
        begin
            out_data_reg.gain_value   <= gain_next;
            out_data_reg.gain_changed <= flag_report;
        end
    end

    assign gain_valid = out_valid_reg;
    assign gain_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: hdl/spectrum_auto_gain_control.sv
// ----------------------------------------------------------------------------
// spectrum_auto_gain_control
// Automatic gain control that tracks the peak of smoothed spectrum bars.
// ----------------------------------------------------------------------------
// Takes one bin level per transfer and sustains one bin per clock cycle while
// no gain result waits: each bin is a read-modify-write of its smoothed level
// in the bin memory, through one read and one write port with a forwarding
// path between back-to-back transfers to the same bin. A frame's gain result
// appears once its last-of-frame bin has passed the queue and the smoothing,
// peak, step and gain stages; a waiting result stalls the back pipeline while
// the four-entry queue keeps taking bins. After reset a clearing pass zeroes
// the bin memory, during which no bin is taken; configuration writes are taken
// at any time and must only be made while the block is idle.
`default_nettype none

module spectrum_auto_gain_control
    import sagc_pkg::*;
#(
    parameter int BINS = SAGC_BINS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        bin_valid,
    output logic             bin_ready,
    input  wire sagc_in_t    bin_data,
    output logic             gain_valid,
    input  wire logic        gain_ready,
    output sagc_out_t        gain_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int QW = $bits(sagc_item_t) + AW;

    sagc_cfg_t       cfg_reg;
    sagc_cfg_t       cfg_next;
    logic            clearing;
    sagc_qstat_t     q_stat;
    logic            push;
    logic            pop;
    sagc_item_t      front_item;
    logic [AW-1:0]   front_addr;
    logic [QW-1:0]   q_rd_data;
    sagc_item_t      head_item;
    logic [AW-1:0]   head_addr;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (sagc_cfg_idx_t'(cfg_index))
                CFG_SMOOTHING_FACTOR:  cfg_next.smoothing_factor  = cfg_data[8:0];
                CFG_MINIMUM_AMPLITUDE: cfg_next.minimum_amplitude = cfg_data[7:0];
                CFG_PEAK_GOAL:         cfg_next.peak_goal         = cfg_data[7:0];
                CFG_STEP_RATE:         cfg_next.step_rate         = cfg_data[7:0];
                CFG_MIN_GAIN:          cfg_next.min_gain          = cfg_data;
                CFG_MAX_GAIN:          cfg_next.max_gain          = cfg_data;
                CFG_CHANGE_THRESHOLD:  cfg_next.change_threshold  = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_factor  <= SAGC_SMOOTHING_RESET;
            cfg_reg.minimum_amplitude <= SAGC_MIN_AMP_RESET;
            cfg_reg.peak_goal         <= SAGC_TARGET_RESET;
            cfg_reg.step_rate         <= SAGC_SPEED_RESET;
            cfg_reg.min_gain          <= SAGC_MIN_GAIN_RESET;
            cfg_reg.max_gain          <= SAGC_MAX_GAIN_RESET;
            cfg_reg.change_threshold  <= SAGC_THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sagc_front #(
        .BINS (BINS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_valid (bin_valid),
        .bin_ready (bin_ready),
        .bin_data  (bin_data),
        .clearing  (clearing),
        .q_stat    (q_stat),
        .push      (push),
        .item      (front_item),
        .addr      (front_addr)
    );

    sagc_queue #(
        .WIDTH (QW),
        .DEPTH (SAGC_QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({front_item, front_addr}),
        .pop     (pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    assign head_item = q_rd_data[QW-1:AW];
    assign head_addr = q_rd_data[AW-1:0];

    sagc_back #(
        .BINS (BINS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_item  (head_item),
        .head_addr  (head_addr),
        .q_stat     (q_stat),
        .pop        (pop),
        .clearing   (clearing),
        .gain_valid (gain_valid),
        .gain_ready (gain_ready),
        .gain_data  (gain_data)
    );

    // no bin transfer while the bin memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !bin_ready)
        else $error("bin taken during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_stat.full))
        else $error("queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n) push |=> !q_stat.empty)
        else $error("pushed bin lost from queue");

endmodule

`default_nettype wire
